// ----- rtl/core/pidc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg: shared constants and types of the clamped pid controller
// Fixed-point formats, accumulator widths and configuration register indexes.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // default sample width, signed q8.8 at 16 bits
  localparam int unsigned DataWidthDef = 16;

  // integral sum is a saturating 32-bit value
  localparam int unsigned IntegWidth = 32;

  // products wrap modulo 2^64 before the fraction shift
  localparam int unsigned AccWidth = 64;

  // fraction bits of the q8.8 format
  localparam int unsigned FracBits = 8;

  // 0.1 in q8.8, rounded to the nearest 1/256
  localparam int unsigned ToleranceReset = 26;

  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgSetpoint      = 3'd0,
    CfgGainP         = 3'd1,
    CfgGainI         = 3'd2,
    CfgGainD         = 3'd3,
    CfgTolerance     = 3'd4,
    CfgLimitsEnabled = 3'd5,
    CfgLowerLimit    = 3'd6,
    CfgUpperLimit    = 3'd7
  } cfg_idx_e;

endpackage

// ----- rtl/core/pidc_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_regs: configuration register file
// Holds setpoint, gains, tolerance and drive limits, written by index.
// ----------------------------------------------------------------------------
module pidc_regs #(
  parameter int unsigned DATA_WIDTH = pidc_pkg::DataWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pidc_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]              cfg_wdata_i,
  output logic signed [DATA_WIDTH-1:0]       setpoint_o,
  output logic signed [DATA_WIDTH-1:0]       gain_p_o,
  output logic signed [DATA_WIDTH-1:0]       gain_i_o,
  output logic signed [DATA_WIDTH-1:0]       gain_d_o,
  output logic [DATA_WIDTH-2:0]              tolerance_o,
  output logic                               limits_enabled_o,
  output logic signed [DATA_WIDTH-1:0]       lower_limit_o,
  output logic signed [DATA_WIDTH-1:0]       upper_limit_o
);

  logic signed [DATA_WIDTH-1:0] setpoint_q, gain_p_q, gain_i_q, gain_d_q;
  logic signed [DATA_WIDTH-1:0] lower_limit_q, upper_limit_q;
  logic [DATA_WIDTH-2:0]        tolerance_q;
  logic                         limits_enabled_q;
  pidc_pkg::cfg_idx_e           cfg_idx;

  assign cfg_idx = pidc_pkg::cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q       <= '0;
      gain_p_q         <= '0;
      gain_i_q         <= '0;
      gain_d_q         <= '0;
      tolerance_q      <= (DATA_WIDTH-1)'(pidc_pkg::ToleranceReset);
      limits_enabled_q <= 1'b0;
      lower_limit_q    <= '0;
      upper_limit_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        pidc_pkg::CfgSetpoint:      setpoint_q       <= $signed(cfg_wdata_i);
        pidc_pkg::CfgGainP:         gain_p_q         <= $signed(cfg_wdata_i);
        pidc_pkg::CfgGainI:         gain_i_q         <= $signed(cfg_wdata_i);
        pidc_pkg::CfgGainD:         gain_d_q         <= $signed(cfg_wdata_i);
        pidc_pkg::CfgTolerance:     tolerance_q      <= cfg_wdata_i[DATA_WIDTH-2:0];
        pidc_pkg::CfgLimitsEnabled: limits_enabled_q <= cfg_wdata_i[0];
        pidc_pkg::CfgLowerLimit:    lower_limit_q    <= $signed(cfg_wdata_i);
        pidc_pkg::CfgUpperLimit:    upper_limit_q    <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign setpoint_o       = setpoint_q;
  assign gain_p_o         = gain_p_q;
  assign gain_i_o         = gain_i_q;
  assign gain_d_o         = gain_d_q;
  assign tolerance_o      = tolerance_q;
  assign limits_enabled_o = limits_enabled_q;
  assign lower_limit_o    = lower_limit_q;
  assign upper_limit_o    = upper_limit_q;

endmodule

// ----- rtl/core/pidc_law.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_law: control law of the pid controller
// Error, saturating integral, three gain products, clamp and band check.
// ----------------------------------------------------------------------------
module pidc_law #(
  parameter int unsigned DATA_WIDTH = pidc_pkg::DataWidthDef
) (
  input  logic signed [DATA_WIDTH-1:0]           measured_i,
  input  logic signed [pidc_pkg::IntegWidth-1:0] integ_i,
  input  logic signed [DATA_WIDTH:0]             last_err_i,
  input  logic signed [DATA_WIDTH-1:0]           setpoint_i,
  input  logic signed [DATA_WIDTH-1:0]           gain_p_i,
  input  logic signed [DATA_WIDTH-1:0]           gain_i_i,
  input  logic signed [DATA_WIDTH-1:0]           gain_d_i,
  input  logic [DATA_WIDTH-2:0]                  tolerance_i,
  input  logic                                   limits_enabled_i,
  input  logic signed [DATA_WIDTH-1:0]           lower_limit_i,
  input  logic signed [DATA_WIDTH-1:0]           upper_limit_i,
  output logic signed [pidc_pkg::IntegWidth-1:0] integ_o,
  output logic signed [DATA_WIDTH:0]             err_o,
  output logic signed [DATA_WIDTH-1:0]           drive_o,
  output logic                                   in_band_o
);

  localparam int unsigned IW   = pidc_pkg::IntegWidth;
  localparam int unsigned AW   = pidc_pkg::AccWidth;
  localparam int unsigned SumW = ((IW > DATA_WIDTH + 1) ? IW : DATA_WIDTH + 1) + 1;
  localparam int unsigned BW   = DATA_WIDTH + 2;
  localparam int unsigned PwP  = 2 * DATA_WIDTH + 1;
  localparam int unsigned PwI  = DATA_WIDTH + IW;
  localparam int unsigned PwD  = 2 * DATA_WIDTH + 2;

  localparam logic signed [AW-1:0] DMax = (AW'(1) <<< (DATA_WIDTH - 1)) - AW'(1);
  localparam logic signed [AW-1:0] DMin = -DMax - AW'(1);
  localparam logic signed [IW-1:0] IMax = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] IMin = {1'b1, {(IW-1){1'b0}}};

  logic signed [DATA_WIDTH:0]   err;
  logic signed [DATA_WIDTH+1:0] change;
  logic signed [SumW-1:0]       sum_raw;
  logic signed [IW-1:0]         sum_sat;
  logic signed [PwP-1:0]        prod_p;
  logic signed [PwI-1:0]        prod_i;
  logic signed [PwD-1:0]        prod_d;
  logic signed [AW-1:0]         total;
  logic signed [AW-1:0]         lower_ext, upper_ext;
  logic signed [BW-1:0]         band_lo, band_hi, drive_ext;

  assign err     = (DATA_WIDTH+1)'(setpoint_i) - (DATA_WIDTH+1)'(measured_i);
  assign change  = (DATA_WIDTH+2)'(err) - (DATA_WIDTH+2)'(last_err_i);
  assign sum_raw = SumW'(integ_i) + SumW'(err);

  // upper bits all equal to the sign means the sum fits in the integral width
  always_comb begin
    if (sum_raw[SumW-1:IW-1] == {(SumW-IW+1){sum_raw[SumW-1]}}) begin
      sum_sat = sum_raw[IW-1:0];
    end else if (sum_raw[SumW-1]) begin
      sum_sat = IMin;
    end else begin
      sum_sat = IMax;
    end
  end

  // products at their natural width
  assign prod_p = PwP'(gain_p_i) * PwP'(err);
  assign prod_i = PwI'(gain_i_i) * PwI'(sum_sat);
  assign prod_d = PwD'(gain_d_i) * PwD'(change);

  // products wrap at the accumulator width, then drop the fraction bits
  assign total  = (AW'(prod_p) >>> pidc_pkg::FracBits) + (AW'(prod_i) >>> pidc_pkg::FracBits)
                + (AW'(prod_d) >>> pidc_pkg::FracBits);

  assign lower_ext = AW'(lower_limit_i);
  assign upper_ext = AW'(upper_limit_i);

  always_comb begin
    if (limits_enabled_i) begin
      // with crossed limits a total below the lower limit takes it, all others the upper limit
      if (total < lower_ext) begin
        drive_o = lower_limit_i;
      end else if (total > upper_ext) begin
        drive_o = upper_limit_i;
      end else begin
        drive_o = total[DATA_WIDTH-1:0];
      end
    end else begin
      if (total > DMax) begin
        drive_o = DMax[DATA_WIDTH-1:0];
      end else if (total < DMin) begin
        drive_o = DMin[DATA_WIDTH-1:0];
      end else begin
        drive_o = total[DATA_WIDTH-1:0];
      end
    end
  end

  assign band_lo   = BW'(setpoint_i) - $signed({3'b000, tolerance_i});
  assign band_hi   = BW'(setpoint_i) + $signed({3'b000, tolerance_i});
  assign drive_ext = BW'(drive_o);
  assign in_band_o = (drive_ext >= band_lo) && (drive_ext <= band_hi);

  assign integ_o = sum_sat;
  assign err_o   = err;

endmodule

// ----- rtl/core/pid_controller_clamped_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_top: clamped discrete pid controller
// One measured sample in, one clamped drive value and band flag out.
// ----------------------------------------------------------------------------
// a sample is held in the sample register, its result in the result register
// throughput: one sample per cycle while the output is not stalled, set by the
//   combinational control law between the sample register and the result register
// reset clears the integral sum, the previous error, the pipeline valids
//   and all configuration registers (tolerance resets to 26, i.e. 0.1)
module pid_controller_clamped_top #(
  parameter int unsigned DATA_WIDTH = pidc_pkg::DataWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pidc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]                cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [DATA_WIDTH-1:0]         measured_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [DATA_WIDTH-1:0]         drive_o,
  output logic                                 in_band_o
);

  localparam int unsigned IW = pidc_pkg::IntegWidth;

  logic signed [DATA_WIDTH-1:0] setpoint, gain_p, gain_i, gain_d;
  logic signed [DATA_WIDTH-1:0] lower_limit, upper_limit;
  logic [DATA_WIDTH-2:0]        tolerance;
  logic                         limits_enabled;

  logic                         s1_valid_q;
  logic signed [DATA_WIDTH-1:0] meas_q;
  logic signed [IW-1:0]         integ_q, integ_d;
  logic signed [DATA_WIDTH:0]   last_err_q, last_err_d;
  logic                         out_valid_q;
  logic signed [DATA_WIDTH-1:0] drive_q, drive_d;
  logic                         in_band_q, in_band_d;
  logic                         s1_move, in_take;

  pidc_regs #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .setpoint_o      (setpoint),
    .gain_p_o        (gain_p),
    .gain_i_o        (gain_i),
    .gain_d_o        (gain_d),
    .tolerance_o     (tolerance),
    .limits_enabled_o(limits_enabled),
    .lower_limit_o   (lower_limit),
    .upper_limit_o   (upper_limit)
  );

  pidc_law #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_law (
    .measured_i      (meas_q),
    .integ_i         (integ_q),
    .last_err_i      (last_err_q),
    .setpoint_i      (setpoint),
    .gain_p_i        (gain_p),
    .gain_i_i        (gain_i),
    .gain_d_i        (gain_d),
    .tolerance_i     (tolerance),
    .limits_enabled_i(limits_enabled),
    .lower_limit_i   (lower_limit),
    .upper_limit_i   (upper_limit),
    .integ_o         (integ_d),
    .err_o           (last_err_d),
    .drive_o         (drive_d),
    .in_band_o       (in_band_d)
  );

  // the sample stage moves on when the result register is empty or drained
  assign s1_move    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_err_q  <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= s1_valid_q;
      end
      // controller state advances once per sample, as it enters the result register
      if (s1_valid_q && s1_move) begin
        integ_q    <= integ_d;
        last_err_q <= last_err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      meas_q <= measured_i;
    end
    if (s1_valid_q && s1_move) begin
      drive_q   <= drive_d;
      in_band_q <= in_band_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign in_band_o   = in_band_q;

`ifndef SYNTHESIS
  a_limits_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && limits_enabled && (lower_limit <= upper_limit)
    |-> (drive_q >= lower_limit) && (drive_q <= upper_limit))
    else $error("drive outside enabled limits");

  a_state_only_on_move : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && s1_move) |=> $stable(integ_q) && $stable(last_err_q))
    else $error("controller state changed without a sample");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  a_result_from_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a sample");
`endif

endmodule

// ----- bench/tb_pid_controller_clamped_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_clamped_top: self-checking bench for the clamped pid block
// A directed table walks the register extremes, saturation, clamping and
// crossed limits, then randomly configured phases send samples, with random
// idling on both channels in all but one phase. Typed rows are checked against
// their table values, the rest against a cycle-free control-law predictor.
// ----------------------------------------------------------------------------
module tb_pid_controller_clamped_top;

  localparam int DW = pidc_pkg::DataWidthDef;
  localparam int IWd = pidc_pkg::IntegWidth;
  localparam int StallLimit = 2000;
  localparam logic signed [DW-1:0] DriveMax = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DriveMin = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [IWd-1:0] IntegMax = {1'b0, {(IWd-1){1'b1}}};
  localparam logic signed [IWd-1:0] IntegMin = {1'b1, {(IWd-1){1'b0}}};

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 in_band;
  } ctrl_out_t;

  typedef enum logic {RowCfg, RowSample} row_kind_e;

  // sample rows carry the measured value in value; typed rows hold their own result
  typedef struct packed {
    row_kind_e            kind;
    pidc_pkg::cfg_idx_e   idx;
    logic [DW-1:0]        value;
    logic                 typed;
    logic signed [DW-1:0] want_drive;
    logic                 want_band;
  } dir_row_t;

  localparam int NumDir = 38;
  localparam dir_row_t DirTab [NumDir] = '{
    // reset state: zero gains, zero setpoint, tolerance 0.1
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h0000, 1'b1, 16'sh0000, 1'b1},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h7fff, 1'b1, 16'sh0000, 1'b1},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h8000, 1'b1, 16'sh0000, 1'b1},
    // top tolerance bit is dropped, band stays below zero
    '{RowCfg,    pidc_pkg::CfgTolerance,     16'hffff, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgSetpoint,      16'h8000, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h0000, 1'b1, 16'sh0000, 1'b0},
    // free-running saturation at both ends
    '{RowCfg,    pidc_pkg::CfgSetpoint,      16'h7fff, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgGainP,         16'h7fff, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h8000, 1'b1, 16'sh7fff, 1'b1},
    '{RowCfg,    pidc_pkg::CfgGainP,         16'h8000, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h8000, 1'b1, 16'sh8000, 1'b0},
    // clamp to ordered limits
    '{RowCfg,    pidc_pkg::CfgTolerance,     16'h0000, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgLimitsEnabled, 16'hffff, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgLowerLimit,    16'hff00, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgUpperLimit,    16'h0100, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h8000, 1'b1, 16'shff00, 1'b0},
    '{RowCfg,    pidc_pkg::CfgGainP,         16'h7fff, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h8000, 1'b1, 16'sh0100, 1'b0},
    // crossed limits
    '{RowCfg,    pidc_pkg::CfgLowerLimit,    16'h0100, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgUpperLimit,    16'hff00, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h8000, 1'b1, 16'shff00, 1'b0},
    '{RowCfg,    pidc_pkg::CfgGainP,         16'h8000, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h8000, 1'b1, 16'sh0100, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h7f00, 1'b0, 16'sh0000, 1'b0},
    // all three terms active, limits wide open, then off
    '{RowCfg,    pidc_pkg::CfgGainP,         16'h0100, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgGainI,         16'h0040, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgGainD,         16'h0080, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgSetpoint,      16'h0000, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgTolerance,     16'h001a, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgLowerLimit,    16'h8000, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgUpperLimit,    16'h7fff, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h0100, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'hff00, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h0004, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h0000, 1'b0, 16'sh0000, 1'b0},
    '{RowCfg,    pidc_pkg::CfgLimitsEnabled, 16'h0000, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'h7fff, 1'b0, 16'sh0000, 1'b0},
    '{RowSample, pidc_pkg::CfgSetpoint,      16'hfff0, 1'b0, 16'sh0000, 1'b0}
  };

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             cfg_we_i    = 1'b0;
  logic [pidc_pkg::CfgIdxWidth-1:0] cfg_idx_i   = '0;
  logic [DW-1:0]                    cfg_wdata_i = '0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  logic signed [DW-1:0]             measured_i  = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic signed [DW-1:0]             drive_o;
  logic                             in_band_o;

  bit idle_on = 1'b1;
  int mismatch_cnt = 0;
  ctrl_out_t pending_drives [$];

  // shadow of the controller registers and state
  logic signed [DW-1:0]  sp_q = '0, kp_q = '0, ki_q = '0, kd_q = '0;
  logic signed [DW-1:0]  lo_q = '0, hi_q = '0;
  logic [DW-2:0]         tol_q = (DW-1)'(pidc_pkg::ToleranceReset);
  logic                  lim_en_q = 1'b0;
  logic signed [IWd-1:0] integ_q = '0;
  logic signed [DW:0]    prev_err_q = '0;

  pid_controller_clamped_top #(.DATA_WIDTH(DW)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .measured_i,
    .out_valid_o, .out_stall_i, .drive_o, .in_band_o
  );

  always #5 clk_i = ~clk_i;

  function automatic ctrl_out_t control_law(input logic signed [DW-1:0] meas);
    longint err, sum, p_t, i_t, d_t, total, drv, tol;
    ctrl_out_t res;
    err = longint'(sp_q) - longint'(meas);
    sum = longint'(integ_q) + err;
    if (sum > longint'(IntegMax)) sum = longint'(IntegMax);
    else if (sum < longint'(IntegMin)) sum = longint'(IntegMin);
    p_t = (longint'(kp_q) * err) >>> pidc_pkg::FracBits;
    i_t = (longint'(ki_q) * sum) >>> pidc_pkg::FracBits;
    d_t = (longint'(kd_q) * (err - longint'(prev_err_q))) >>> pidc_pkg::FracBits;
    total = p_t + i_t + d_t;
    if (lim_en_q) begin
      // lower limit wins, so crossed limits pick upper for everything else
      if (total < longint'(lo_q)) drv = longint'(lo_q);
      else if (total > longint'(hi_q)) drv = longint'(hi_q);
      else drv = total;
    end else begin
      if (total > longint'(DriveMax)) drv = longint'(DriveMax);
      else if (total < longint'(DriveMin)) drv = longint'(DriveMin);
      else drv = total;
    end
    tol = longint'(tol_q);
    res.drive = drv[DW-1:0];
    res.in_band = (drv >= longint'(sp_q) - tol) && (drv <= longint'(sp_q) + tol);
    integ_q = sum[IWd-1:0];
    prev_err_q = err[DW:0];
    return res;
  endfunction

  function automatic logic [DW-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return DriveMax;
      1: return DriveMin;
      2: return DW'($urandom);
      3, 4: return '0;
      default: return DW'($urandom_range(0, 512)) - DW'(256);
    endcase
  endfunction

  // called at a falling edge with the write enable low
  task automatic cfg_write(input pidc_pkg::cfg_idx_e idx, input logic [DW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      pidc_pkg::CfgSetpoint:      sp_q = data;
      pidc_pkg::CfgGainP:         kp_q = data;
      pidc_pkg::CfgGainI:         ki_q = data;
      pidc_pkg::CfgGainD:         kd_q = data;
      pidc_pkg::CfgTolerance:     tol_q = data[DW-2:0];
      pidc_pkg::CfgLimitsEnabled: lim_en_q = data[0];
      pidc_pkg::CfgLowerLimit:    lo_q = data;
      pidc_pkg::CfgUpperLimit:    hi_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_sample(input logic signed [DW-1:0] meas, input logic typed,
                             input logic signed [DW-1:0] want_drive, input logic want_band);
    ctrl_out_t res;
    while (idle_on && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      measured_i <= DW'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    measured_i <= meas;
    do @(posedge clk_i); while (in_stall_o);
    res = control_law(meas);
    if (typed) begin
      res.drive = want_drive;
      res.in_band = want_band;
    end
    pending_drives.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatch_cnt < 10) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  always @(negedge clk_i) out_stall_i <= idle_on && ($urandom_range(0, 99) < 35);

  always @(posedge clk_i) begin
    ctrl_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drives.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: drive %0d in_band %0b",
                                drive_o, in_band_o));
      end else begin
        want = pending_drives.pop_front();
        if (drive_o !== want.drive)
          note_mismatch($sformatf("drive expected %0d got %0d", want.drive, drive_o));
        if (in_band_o !== want.in_band)
          note_mismatch($sformatf("in_band expected %0b got %0b (drive %0d)",
                                  want.in_band, in_band_o, drive_o));
      end
    end
  end

  // ends a hung run: no transaction on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("pid_controller_clamped_top regression: fail");
    $finish;
  end

  initial begin
    logic [DW-1:0] meas_v, lo_v, hi_v;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int n = 0; n < NumDir; n++) begin
      if (DirTab[n].kind == RowCfg) begin
        settle();
        cfg_write(DirTab[n].idx, DirTab[n].value);
      end else begin
        send_sample(DirTab[n].value, DirTab[n].typed, DirTab[n].want_drive,
                    DirTab[n].want_band);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      idle_on = (ph != 4);
      case ($urandom_range(0, 3))
        0: cfg_write(pidc_pkg::CfgSetpoint, DriveMax);
        1: cfg_write(pidc_pkg::CfgSetpoint, DriveMin);
        2: cfg_write(pidc_pkg::CfgSetpoint, DW'($urandom));
        default: cfg_write(pidc_pkg::CfgSetpoint, DW'($urandom_range(0, 2048)) - DW'(1024));
      endcase
      cfg_write(pidc_pkg::CfgGainP, pick_gain());
      cfg_write(pidc_pkg::CfgGainI, pick_gain());
      cfg_write(pidc_pkg::CfgGainD, pick_gain());
      cfg_write(pidc_pkg::CfgTolerance,
                $urandom_range(0, 1) ? DW'($urandom) : DW'($urandom_range(0, 64)));
      cfg_write(pidc_pkg::CfgLimitsEnabled, DW'($urandom));
      lo_v = DW'($urandom_range(0, 4096)) - DW'(2048);
      hi_v = lo_v + DW'($urandom_range(0, 4096));
      case ($urandom_range(0, 9))
        0: begin
          lo_v = DriveMin;
          hi_v = DriveMax;
        end
        1: begin
          lo_v = DriveMax;
          hi_v = DriveMin;
        end
        2, 3: begin
          meas_v = lo_v;
          lo_v = hi_v;
          hi_v = meas_v;
        end
        default: ;
      endcase
      cfg_write(pidc_pkg::CfgLowerLimit, lo_v);
      cfg_write(pidc_pkg::CfgUpperLimit, hi_v);
      for (int k = 0; k < 85; k++) begin
        case ($urandom_range(0, 9))
          0: meas_v = DriveMax;
          1: meas_v = DriveMin;
          2, 3: meas_v = DW'($urandom);
          default: meas_v = sp_q + DW'($urandom_range(0, 128)) - DW'(64);
        endcase
        send_sample(meas_v, 1'b0, '0, 1'b0);
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("pid_controller_clamped_top regression: pass");
    end else begin
      $display("pid_controller_clamped_top regression: fail");
    end
    $finish;
  end

endmodule
